/* hdl/pnbcd_pkg.sv */
package pnbcd_pkg;

    localparam int VAL_W    = 12;
    localparam int DIGIT_W  = 4;
    localparam int COLOR_W  = 3;
    localparam int RELOAD_W = 16;
    localparam int DIV_W    = 4;
    localparam int LFSR_W   = 8;

    localparam logic [DIGIT_W-1:0]  BLANK_DIGIT  = 4'd10;
    localparam logic [LFSR_W-1:0]   LFSR_SEED    = 8'd5;
    localparam logic [RELOAD_W-1:0] RELOAD_RESET = 16'd32768;
    localparam logic [VAL_W-1:0]    THRESH_RESET = 12'd2000;
    localparam logic [DIV_W-1:0]    DIV_RESET    = 4'd1;
    localparam logic [DIV_W-1:0]    COUNT_RESET  = 4'd1;
    localparam logic [COLOR_W-1:0]  COLOR_NORMAL = 3'd0;

    // period reload table
    localparam int PERIOD_STEPS   = 8;
    localparam int PERIOD_DIV     = 513;
    localparam int PERIOD_BASE    = 4096;
    localparam int PERIOD_SPAN    = 57344;
    localparam int PERIOD_CAP     = 61439;
    localparam int PERIOD_STEP    = PERIOD_SPAN / (PERIOD_STEPS - 1);
    localparam int PERIOD_RAW_MAX = ((1 << VAL_W) - 1) / PERIOD_DIV;
    localparam int IDX_W          = $clog2(PERIOD_STEPS);

    typedef logic [IDX_W-1:0] t_period_idx;

    typedef enum logic {
        REQ_TICK   = 1'b0,
        REQ_SAMPLE = 1'b1
    } t_req;

    typedef enum logic {
        CFG_LIGHT_THRESHOLD = 1'b0,
        CFG_TICK_DIVIDE     = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [DIGIT_W-1:0] thousands;
        logic [DIGIT_W-1:0] hundreds;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] ones;
    } t_digits;

    // pot / 513 by threshold compares, saturated at the last table entry
    function automatic t_period_idx period_index(input logic [VAL_W-1:0] pot);
        int unsigned cnt;
        cnt = 0;
        for (int k = 1; k <= PERIOD_RAW_MAX; k++) begin
            if (pot >= VAL_W'(k * PERIOD_DIV)) begin
                cnt++;
            end
        end
        if (cnt > PERIOD_STEPS - 1) begin
            cnt = PERIOD_STEPS - 1;
        end
        return IDX_W'(cnt);
    endfunction

    function automatic logic [RELOAD_W-1:0] period_reload(input t_period_idx idx);
        int unsigned e;
        e = PERIOD_BASE + int'(idx) * PERIOD_STEP;
        if (e > PERIOD_CAP) begin
            e = PERIOD_CAP;
        end
        return RELOAD_W'(e + PERIOD_BASE);
    endfunction

endpackage

/* hdl/pnbcd_in_if.sv */
interface pnbcd_in_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [pnbcd_pkg::VAL_W-1:0] light_sample;
    logic [pnbcd_pkg::VAL_W-1:0] pot_sample;

    modport source (output valid, req_type, light_sample, pot_sample, input ready);
    modport sink   (input valid, req_type, light_sample, pot_sample, output ready);
endinterface

/* hdl/pnbcd_out_if.sv */
interface pnbcd_out_if;
    logic                           valid;
    logic                           ready;
    logic [pnbcd_pkg::DIGIT_W-1:0]  digit_thousands;
    logic [pnbcd_pkg::DIGIT_W-1:0]  digit_hundreds;
    logic [pnbcd_pkg::DIGIT_W-1:0]  digit_tens;
    logic [pnbcd_pkg::DIGIT_W-1:0]  digit_ones;
    logic [pnbcd_pkg::COLOR_W-1:0]  led_color;
    logic [pnbcd_pkg::RELOAD_W-1:0] period_reload;
    logic                           random_mode;

    modport source (output valid, digit_thousands, digit_hundreds, digit_tens, digit_ones,
                    led_color, period_reload, random_mode, input ready);
    modport sink   (input valid, digit_thousands, digit_hundreds, digit_tens, digit_ones,
                    led_color, period_reload, random_mode, output ready);
endinterface

/* hdl/pnbcd_decimal.sv */
module pnbcd_decimal (
    input  logic [pnbcd_pkg::VAL_W-1:0] i_value,
    output pnbcd_pkg::t_digits          o_digits
);

    logic [2:0] th;
    logic [9:0] rem_th;
    logic [3:0] hu;
    logic [6:0] rem_hu;
    logic [3:0] te;
    logic [3:0] on;

    always_comb begin
        th = '0;
        for (int k = 1; k <= 4; k++) begin
            if (i_value >= 12'(k * 1000)) begin
                th = 3'(k);
            end
        end
        rem_th = 10'(i_value - 12'(int'(th) * 1000));

        hu = '0;
        for (int k = 1; k <= 9; k++) begin
            if (rem_th >= 10'(k * 100)) begin
                hu = 4'(k);
            end
        end
        rem_hu = 7'(rem_th - 10'(int'(hu) * 100));

        te = '0;
        for (int k = 1; k <= 9; k++) begin
            if (rem_hu >= 7'(k * 10)) begin
                te = 4'(k);
            end
        end
        on = 4'(rem_hu - 7'(int'(te) * 10));

        // leading zero blanking, ones always shown
        o_digits.ones      = on;
        o_digits.tens      = te;
        o_digits.hundreds  = hu;
        o_digits.thousands = {1'b0, th};
        if (th == 3'd0) begin
            o_digits.thousands = pnbcd_pkg::BLANK_DIGIT;
            if (hu == 4'd0) begin
                o_digits.hundreds = pnbcd_pkg::BLANK_DIGIT;
                if (te == 4'd0) begin
                    o_digits.tens = pnbcd_pkg::BLANK_DIGIT;
                end
            end
        end
    end

endmodule

/* hdl/pn_sequence_bcd_display_unit.sv */
// Results are registered: an accepted word's result word is presented in the next cycle.
// Throughput: one word per cycle; the input stalls only while a result word
// waits on the output register. Ticks that give no result are absorbed.
// Reset (synchronous, active low): LFSR seed 5, prescaler 1, normal mode,
// all digits blank, color 0, period reload 32768, threshold 2000, divide 1.
module pn_sequence_bcd_display_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  pnbcd_pkg::t_cfg_idx           i_cfg_idx,
    input  logic [pnbcd_pkg::VAL_W-1:0]   i_cfg_wdata,
    pnbcd_in_if.sink                      i_req,
    pnbcd_out_if.source                   o_res
);

    logic [pnbcd_pkg::VAL_W-1:0]    r_threshold;
    logic [pnbcd_pkg::DIV_W-1:0]    r_divide;
    logic [pnbcd_pkg::LFSR_W-1:0]   r_lfsr,   n_lfsr;
    logic [pnbcd_pkg::DIV_W-1:0]    r_count,  n_count;
    logic                           r_mode,   n_mode;
    pnbcd_pkg::t_digits             r_digits, n_digits;
    logic [pnbcd_pkg::COLOR_W-1:0]  r_color,  n_color;
    logic [pnbcd_pkg::RELOAD_W-1:0] r_reload, n_reload;
    logic                           r_out_valid, n_out_valid;

    logic                           accept;
    logic                           is_sample;
    logic                           fire;
    logic [pnbcd_pkg::LFSR_W-1:0]   lfsr_step;
    logic [pnbcd_pkg::VAL_W-1:0]    dec_in;
    pnbcd_pkg::t_digits             dec_digits;
    logic [4:0]                     mod_s1;
    logic [3:0]                     mod_s2;
    logic [2:0]                     mod_r;
    logic [pnbcd_pkg::COLOR_W-1:0]  lfsr_color;

    assign i_req.ready = !r_out_valid || o_res.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign is_sample   = i_req.req_type == pnbcd_pkg::REQ_SAMPLE;
    assign fire        = (r_count == r_divide) && r_mode;

    assign lfsr_step = {r_lfsr[4] ^ r_lfsr[3] ^ r_lfsr[2] ^ r_lfsr[0], r_lfsr[7:1]};
    assign dec_in    = is_sample ? i_req.pot_sample
                                 : {{(pnbcd_pkg::VAL_W - pnbcd_pkg::LFSR_W){1'b0}}, lfsr_step};

    pnbcd_decimal u_decimal (
        .i_value  (dec_in),
        .o_digits (dec_digits)
    );

    // mod 7 by folding octal digits (8 == 1 mod 7)
    always_comb begin
        mod_s1 = {2'b0, lfsr_step[2:0]} + {2'b0, lfsr_step[5:3]} + {3'b0, lfsr_step[7:6]};
        mod_s2 = {1'b0, mod_s1[2:0]} + {2'b0, mod_s1[4:3]};
        mod_r  = (mod_s2 >= 4'd7) ? 3'(mod_s2 - 4'd7) : mod_s2[2:0];
        lfsr_color = mod_r + 3'd1;
    end

    always_comb begin
        n_lfsr      = r_lfsr;
        n_count     = r_count;
        n_mode      = r_mode;
        n_digits    = r_digits;
        n_color     = r_color;
        n_reload    = r_reload;
        n_out_valid = r_out_valid && !o_res.ready;
        if (accept) begin
            if (!is_sample) begin
                if (r_count >= r_divide) begin
                    n_count = pnbcd_pkg::COUNT_RESET;
                end else begin
                    n_count = r_count + 1'b1;
                end
                if (fire) begin
                    n_lfsr      = lfsr_step;
                    n_digits    = dec_digits;
                    n_color     = lfsr_color;
                    n_out_valid = 1'b1;
                end
            end else begin
                n_out_valid = 1'b1;
                if (i_req.light_sample > r_threshold) begin
                    n_mode   = 1'b0;
                    n_digits = dec_digits;
                    n_color  = pnbcd_pkg::COLOR_NORMAL;
                end else begin
                    n_mode   = 1'b1;
                    n_reload = pnbcd_pkg::period_reload(
                                   pnbcd_pkg::period_index(i_req.pot_sample));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= pnbcd_pkg::THRESH_RESET;
            r_divide    <= pnbcd_pkg::DIV_RESET;
            r_lfsr      <= pnbcd_pkg::LFSR_SEED;
            r_count     <= pnbcd_pkg::COUNT_RESET;
            r_mode      <= 1'b0;
            r_digits    <= {4{pnbcd_pkg::BLANK_DIGIT}};
            r_color     <= pnbcd_pkg::COLOR_NORMAL;
            r_reload    <= pnbcd_pkg::RELOAD_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_lfsr      <= n_lfsr;
            r_count     <= n_count;
            r_mode      <= n_mode;
            r_digits    <= n_digits;
            r_color     <= n_color;
            r_reload    <= n_reload;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pnbcd_pkg::CFG_LIGHT_THRESHOLD: begin
                        r_threshold <= i_cfg_wdata;
                    end
                    pnbcd_pkg::CFG_TICK_DIVIDE: begin
                        r_divide <= i_cfg_wdata[pnbcd_pkg::DIV_W-1:0];
                    end
                    default: begin
                        r_threshold <= r_threshold;
                    end
                endcase
            end
        end
    end

    // displayed state only changes on words that produce a result
    assign o_res.valid           = r_out_valid;
    assign o_res.digit_thousands = r_digits.thousands;
    assign o_res.digit_hundreds  = r_digits.hundreds;
    assign o_res.digit_tens      = r_digits.tens;
    assign o_res.digit_ones      = r_digits.ones;
    assign o_res.led_color       = r_color;
    assign o_res.period_reload   = r_reload;
    assign o_res.random_mode     = r_mode;

endmodule
